### rtl/bta_pkg.sv
// shared types, constants and the control store for the block table allocator
// no dependencies; used by every module of the block by scoped names
package bta_pkg;

  // default sizing; the block size is a power of two
  localparam int unsigned BLOCK_BYTES_DEF = 4096;
  localparam int unsigned MAX_BLOCKS_DEF  = 1024;

  // region base keeps only the bits at and above this position
  localparam int unsigned BASE_LSB = 12;

  // operand width: 32-bit byte count plus round-up carry
  localparam int unsigned OPND_W = 33;

  // table entry layout
  localparam int unsigned ENT_W         = 3;
  localparam int unsigned ENT_TAKEN_BIT = 0;
  localparam int unsigned ENT_FIRST_BIT = 1;
  localparam int unsigned ENT_NEXT_BIT  = 2;

  // configuration port
  localparam int unsigned CFG_AW        = 3;
  localparam logic        REG_HEAP_BASE = 1'b0;
  localparam logic        REG_BLK_COUNT = 1'b1;
  localparam logic [31:0] HEAP_BASE_RST = 32'h0000_0000;
  localparam logic [10:0] BLK_COUNT_RST = 11'd1024;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic        func;
    logic [31:0] alloc_bytes;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    status_t     status;
  } rsp_t;

  // datapath operations
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLR,
    ACT_TO_BLOCKS,
    ACT_SCAN_INIT,
    ACT_SCAN,
    ACT_MARK_INIT,
    ACT_MARK,
    ACT_RES_NOFIT,
    ACT_RES_ALLOC,
    ACT_FREE_INIT,
    ACT_CHAIN,
    ACT_RES_FREE,
    ACT_RES_RANGE
  } act_t;

  // jump conditions
  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NOSTART,
    COND_CLR_MORE,
    COND_FUNC_FREE,
    COND_NEED_BAD,
    COND_SCAN_GO,
    COND_FOUND,
    COND_MARK_MORE,
    COND_FREE_BAD,
    COND_CHAIN_MORE
  } cond_t;

  typedef logic [3:0] upc_t;

  // program step addresses
  localparam upc_t P_CLR       = 4'd0;
  localparam upc_t P_IDLE      = 4'd1;
  localparam upc_t P_TO_BLOCKS = 4'd2;
  localparam upc_t P_BRANCH    = 4'd3;
  localparam upc_t P_NEED_CHK  = 4'd4;
  localparam upc_t P_SCAN      = 4'd5;
  localparam upc_t P_FOUND_CHK = 4'd6;
  localparam upc_t P_FAIL      = 4'd7;
  localparam upc_t P_MARK      = 4'd8;
  localparam upc_t P_ALLOC_OK  = 4'd9;
  localparam upc_t P_FREE_CHK  = 4'd10;
  localparam upc_t P_CHAIN     = 4'd11;
  localparam upc_t P_FREE_OK   = 4'd12;
  localparam upc_t P_FREE_BAD  = 4'd13;

  typedef struct packed {
    logic  idle;
    act_t  act;
    cond_t cond;
    upc_t  target;
  } cw_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic clr_more;
    logic func_free;
    logic need_bad;
    logic scan_go;
    logic found;
    logic mark_more;
    logic free_bad;
    logic chain_more;
  } flags_t;

  // control store: taken jump goes to target, else to the next step
  function automatic cw_t bta_rom(upc_t a);
    cw_t w;
    case (a)
      P_CLR:       w = '{1'b0, ACT_CLR,       COND_CLR_MORE,   P_CLR};
      P_IDLE:      w = '{1'b1, ACT_NONE,      COND_NOSTART,    P_IDLE};
      P_TO_BLOCKS: w = '{1'b0, ACT_TO_BLOCKS, COND_NEVER,      P_IDLE};
      P_BRANCH:    w = '{1'b0, ACT_SCAN_INIT, COND_FUNC_FREE,  P_FREE_CHK};
      P_NEED_CHK:  w = '{1'b0, ACT_NONE,      COND_NEED_BAD,   P_FAIL};
      P_SCAN:      w = '{1'b0, ACT_SCAN,      COND_SCAN_GO,    P_SCAN};
      P_FOUND_CHK: w = '{1'b0, ACT_MARK_INIT, COND_FOUND,      P_MARK};
      P_FAIL:      w = '{1'b0, ACT_RES_NOFIT, COND_ALWAYS,     P_IDLE};
      P_MARK:      w = '{1'b0, ACT_MARK,      COND_MARK_MORE,  P_MARK};
      P_ALLOC_OK:  w = '{1'b0, ACT_RES_ALLOC, COND_ALWAYS,     P_IDLE};
      P_FREE_CHK:  w = '{1'b0, ACT_FREE_INIT, COND_FREE_BAD,   P_FREE_BAD};
      P_CHAIN:     w = '{1'b0, ACT_CHAIN,     COND_CHAIN_MORE, P_CHAIN};
      P_FREE_OK:   w = '{1'b0, ACT_RES_FREE,  COND_ALWAYS,     P_IDLE};
      P_FREE_BAD:  w = '{1'b0, ACT_RES_RANGE, COND_ALWAYS,     P_IDLE};
      default:     w = '{1'b0, ACT_NONE,      COND_ALWAYS,     P_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/bta_seq.sv
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on bta_pkg
module bta_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  bta_pkg::flags_t flags,
  output bta_pkg::cw_t    cw
);

  bta_pkg::upc_t upc_r;
  bta_pkg::upc_t upc_nxt;
  logic          take;

  assign cw = bta_pkg::bta_rom(upc_r);

  always_comb begin
    case (cw.cond)
      bta_pkg::COND_ALWAYS:     take = 1'b1;
      bta_pkg::COND_NEVER:      take = 1'b0;
      bta_pkg::COND_NOSTART:    take = !start;
      bta_pkg::COND_CLR_MORE:   take = flags.clr_more;
      bta_pkg::COND_FUNC_FREE:  take = flags.func_free;
      bta_pkg::COND_NEED_BAD:   take = flags.need_bad;
      bta_pkg::COND_SCAN_GO:    take = flags.scan_go;
      bta_pkg::COND_FOUND:      take = flags.found;
      bta_pkg::COND_MARK_MORE:  take = flags.mark_more;
      bta_pkg::COND_FREE_BAD:   take = flags.free_bad;
      bta_pkg::COND_CHAIN_MORE: take = flags.chain_more;
      default:                  take = 1'b1;
    endcase
    upc_nxt = take ? cw.target : upc_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= bta_pkg::P_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/bta_dp.sv
// allocator datapath: block table memory, block conversion, scan and mark registers
// depends on bta_pkg; driven by the control words of bta_seq
module bta_dp #(
  parameter int unsigned MAX_BLOCKS  = bta_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = bta_pkg::BLOCK_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bta_pkg::cw_t    cw,
  input  logic            accept,
  input  bta_pkg::req_t   in_req,
  input  logic [31:0]     heap_base,
  input  logic [10:0]     block_count,
  output bta_pkg::flags_t flags,
  output logic            out_valid,
  output bta_pkg::rsp_t   out_data
);

  localparam int unsigned IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 2);
  localparam int unsigned XW   = CNTW + 1;
  localparam int unsigned BSH  = $clog2(BLOCK_BYTES);
  localparam int unsigned DW   = bta_pkg::OPND_W;
  localparam int unsigned EW   = bta_pkg::ENT_W;
  localparam int unsigned BL   = bta_pkg::BASE_LSB;

  localparam logic [DW-1:0]   ROUND_UP = DW'(BLOCK_BYTES - 1);
  localparam logic [31:0]     BB32     = 32'(BLOCK_BYTES);
  localparam logic [31:0]     MAX32    = 32'(MAX_BLOCKS);
  localparam logic [CNTW-1:0] CLR_LAST = CNTW'(MAX_BLOCKS - 1);
  localparam logic [CNTW-1:0] MAX_CNT  = CNTW'(MAX_BLOCKS);

  logic [EW-1:0] tbl_mem [0:MAX_BLOCKS-1];

  logic                      func_r,  func_nxt;
  logic [31:0]               op_r,    op_nxt;
  logic                      below_r, below_nxt;
  logic [DW-1:0]             dvd_r,   dvd_nxt;
  logic [CNTW-1:0]           idx_r,   idx_nxt;
  logic [CNTW-1:0]           run_r,   run_nxt;
  logic [CNTW-1:0]           start_r, start_nxt;
  logic                      found_r, found_nxt;
  logic [31:0]               prod_r,  prod_nxt;
  logic [EW-1:0]             rd_r;
  logic                      out_valid_r, out_valid_nxt;
  bta_pkg::rsp_t             out_data_r,  out_data_nxt;

  logic          mem_we;
  logic [EW-1:0] mem_wdata;
  logic [31:0]   base;
  logic [CNTW-1:0] tot;
  logic          in_tab;
  logic          hit;
  logic          not_last;

  assign base   = {heap_base[31:BL], BL'(0)};
  assign tot    = ({21'd0, block_count} > MAX32) ? MAX_CNT : CNTW'(block_count);
  assign in_tab = idx_r < tot;
  assign hit    = in_tab && !rd_r[bta_pkg::ENT_TAKEN_BIT]
                  && ((DW'(run_r) + DW'(1)) == dvd_r);
  assign not_last = (XW'(idx_r) + XW'(1)) != (XW'(start_r) + XW'(run_r));

  always_comb begin
    flags.clr_more   = idx_r != CLR_LAST;
    flags.func_free  = func_r == bta_pkg::FUNC_FREE;
    flags.need_bad   = (dvd_r == '0) || (dvd_r > DW'(tot));
    flags.scan_go    = in_tab && !hit;
    flags.found      = found_r;
    flags.mark_more  = not_last;
    flags.free_bad   = below_r || (dvd_r >= DW'(tot));
    flags.chain_more = rd_r[bta_pkg::ENT_NEXT_BIT]
                       && ((XW'(idx_r) + XW'(1)) < XW'(tot));
  end

  always_comb begin
    func_nxt      = func_r;
    op_nxt        = op_r;
    below_nxt     = below_r;
    dvd_nxt       = dvd_r;
    idx_nxt       = idx_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    found_nxt     = found_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = '0;

    if (accept) begin
      func_nxt = in_req.func;
      op_nxt   = (in_req.func == bta_pkg::FUNC_FREE) ? in_req.free_address
                                                      : in_req.alloc_bytes;
    end

    case (cw.act)
      bta_pkg::ACT_CLR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + CNTW'(1);
      end
      bta_pkg::ACT_TO_BLOCKS: begin
        // free: block index of the offset; alloc: byte count rounded up to blocks
        if (func_r == bta_pkg::FUNC_FREE) begin
          dvd_nxt   = {1'b0, op_r - base} >> BSH;
          below_nxt = op_r < base;
        end else begin
          dvd_nxt   = ({1'b0, op_r} + ROUND_UP) >> BSH;
          below_nxt = 1'b0;
        end
      end
      bta_pkg::ACT_SCAN_INIT: begin
        idx_nxt   = '0;
        run_nxt   = '0;
        start_nxt = '0;
        found_nxt = 1'b0;
      end
      bta_pkg::ACT_SCAN: begin
        if (in_tab) begin
          if (rd_r[bta_pkg::ENT_TAKEN_BIT]) begin
            run_nxt = '0;
          end else begin
            if (run_r == '0) begin
              start_nxt = idx_r;
            end
            run_nxt = run_r + CNTW'(1);
          end
        end
        found_nxt = hit;
        idx_nxt   = idx_r + CNTW'(1);
      end
      bta_pkg::ACT_MARK_INIT: begin
        idx_nxt  = start_r;
        prod_nxt = 32'(start_r) * BB32;
      end
      bta_pkg::ACT_MARK: begin
        mem_we = 1'b1;
        mem_wdata[bta_pkg::ENT_TAKEN_BIT] = 1'b1;
        mem_wdata[bta_pkg::ENT_FIRST_BIT] = idx_r == start_r;
        mem_wdata[bta_pkg::ENT_NEXT_BIT]  = not_last;
        idx_nxt = idx_r + CNTW'(1);
      end
      bta_pkg::ACT_RES_NOFIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{32'd0, bta_pkg::ST_NOFIT};
      end
      bta_pkg::ACT_RES_ALLOC: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{base + prod_r, bta_pkg::ST_OK};
      end
      bta_pkg::ACT_FREE_INIT: begin
        idx_nxt = CNTW'(dvd_r);
      end
      bta_pkg::ACT_CHAIN: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + CNTW'(1);
      end
      bta_pkg::ACT_RES_FREE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{32'd0, bta_pkg::ST_OK};
      end
      bta_pkg::ACT_RES_RANGE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{32'd0, bta_pkg::ST_RANGE};
      end
      default: begin
      end
    endcase
  end

  // table memory; read follows the next index so rd_r always shows entry idx_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[idx_r[IW-1:0]] <= mem_wdata;
    end
    rd_r <= tbl_mem[idx_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    op_r       <= op_nxt;
    below_r    <= below_nxt;
    dvd_r      <= dvd_nxt;
    run_r      <= run_nxt;
    start_r    <= start_nxt;
    found_r    <= found_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/block_table_heap_allocator_top.sv
// top level of the first-fit block table allocator: config registers, sequencer, datapath
// depends on bta_pkg, bta_seq and bta_dp
//
// channel   direction  handshake                      payload
// in_       in         start & !busy accepts request  in_req  (bta_pkg::req_t)
// out_      out        out_valid, one cycle strobe    out_data (bta_pkg::rsp_t)
// cfg_      in         apb write at psel&penable      pwdata/prdata, paddr 3 bits
//
// after reset the table is swept to all free, one entry per cycle,
// with busy high; config writes are taken during the sweep
// one request at a time; bytes and addresses turn into blocks with a shift in a single
// step, so the user must keep BLOCK_BYTES a power of two; the block does not check it
// allocate: bytes are rounded up to blocks, the table is scanned from entry 0 for the
// first free run that is long enough, and the run is marked taken; a failed scan ends
// in no-fit; free: the address becomes a block index and its chain is cleared;
// zero-size or oversized allocations answer no-fit, out-of-range frees answer range
// the result strobe cannot be held off; busy drops in the cycle the result shows
module block_table_heap_allocator_top #(
  parameter int unsigned MAX_BLOCKS  = bta_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = bta_pkg::BLOCK_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  bta_pkg::req_t              in_req,
  // result channel
  output logic                       out_valid,
  output bta_pkg::rsp_t              out_data,
  // apb config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bta_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [31:0]     heap_base_r,   heap_base_nxt;
  logic [10:0]     block_count_r, block_count_nxt;
  logic            cfg_wr;
  logic            accept;
  bta_pkg::cw_t    cw;
  bta_pkg::flags_t flags;

  // no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register select is the word address; byte offset bits are ignored
  always_comb begin
    heap_base_nxt   = heap_base_r;
    block_count_nxt = block_count_r;
    if (cfg_wr) begin
      case (paddr[2])
        bta_pkg::REG_HEAP_BASE: heap_base_nxt   = pwdata;
        bta_pkg::REG_BLK_COUNT: block_count_nxt = pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bta_pkg::REG_HEAP_BASE: prdata = heap_base_r;
      bta_pkg::REG_BLK_COUNT: prdata = {21'd0, block_count_r};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= bta_pkg::HEAP_BASE_RST;
      block_count_r <= bta_pkg::BLK_COUNT_RST;
    end else begin
      heap_base_r   <= heap_base_nxt;
      block_count_r <= block_count_nxt;
    end
  end

  // only the idle step of the program takes a request
  assign busy   = !cw.idle;
  assign accept = start && cw.idle;

  bta_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .cw    (cw)
  );

  bta_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cw          (cw),
    .accept      (accept),
    .in_req      (in_req),
    .heap_base   (heap_base_r),
    .block_count (block_count_r),
    .flags       (flags),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

### rtl/bta_chk.sv
// port-level checks for the block table allocator, bound to the top level
// depends on bta_pkg and block_table_heap_allocator_top
module bta_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input bta_pkg::rsp_t out_data
);

  // reset starts the table sweep
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy not raised after reset");

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after a request");

  // a result shows only as the block goes idle, and only for one cycle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy ##1 !out_valid))
    else $error("result strobe while busy or held");

  // failures carry a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != bta_pkg::ST_OK) |-> out_data.result_address == 32'd0)
    else $error("nonzero address on a failed request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == bta_pkg::ST_OK || out_data.status == bta_pkg::ST_NOFIT
                   || out_data.status == bta_pkg::ST_RANGE))
    else $error("undefined status code");

endmodule

bind block_table_heap_allocator_top bta_chk u_bta_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
